### hw/rtl/mss_pkg.sv
// ----------------------------------------------------------------------------
// mss_pkg
// Shared types and constants for the multi-stack shared slot store.
// ----------------------------------------------------------------------------
package mss_pkg;

  // sizing of the store and the stack table
  localparam int NUM_STACKS = 8;
  localparam int DEPTH      = 256;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int PTR_W      = ADDR_W + 1;
  localparam int STK_W      = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

  // fixed field widths
  localparam int SEL_W  = 3;
  localparam int DATA_W = 32;
  localparam int SELX_W = (STK_W > SEL_W) ? STK_W : SEL_W;

  // slot pointer, with the null pointer one past the last slot
  typedef logic [PTR_W-1:0] ptr_t;
  localparam ptr_t NULL_PTR = PTR_W'(DEPTH);

  // operation codes
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // control sequencer states
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // slot store read request
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } slot_rd_t;

  // slot store write request
  typedef struct packed {
    logic              link_en;
    logic              data_en;
    logic [ADDR_W-1:0] addr;
    ptr_t              link;
    logic [DATA_W-1:0] data;
  } slot_wr_t;

endpackage

### hw/rtl/mss_slot_store.sv
// ----------------------------------------------------------------------------
// mss_slot_store
// Slot data and link memories with one registered read port and one write
// port. A fill count stands in for the reset image of the link memory: slots
// at or above it were never handed out and link to the next slot in order.
// ----------------------------------------------------------------------------
module mss_slot_store (
  input  logic                      clk,
  input  logic                      rst,
  input  mss_pkg::slot_rd_t         rd,
  input  mss_pkg::slot_wr_t         wr,
  output mss_pkg::ptr_t             rd_link,
  output logic [mss_pkg::DATA_W-1:0] rd_data
);

  logic [mss_pkg::DATA_W-1:0] slot_data [mss_pkg::DEPTH];
  mss_pkg::ptr_t              slot_link [mss_pkg::DEPTH];

  mss_pkg::ptr_t              fill;
  mss_pkg::ptr_t              link_q;
  mss_pkg::ptr_t              seq_q;
  logic                       unw_q;
  logic [mss_pkg::DATA_W-1:0] data_q;

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (wr.link_en) begin
      slot_link[wr.addr] <= wr.link;
    end
    if (wr.data_en) begin
      slot_data[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      link_q <= slot_link[rd.addr];
      data_q <= slot_data[rd.addr];
      unw_q  <= ({1'b0, rd.addr} >= fill);
      seq_q  <= {1'b0, rd.addr} + mss_pkg::PTR_W'(1);
    end
  end

  // fill count: slots are first handed out in address order
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (wr.link_en && ({1'b0, wr.addr} == fill)) begin
      fill <= fill + mss_pkg::PTR_W'(1);
    end
  end

  // never-written slot links onward; out-of-range links read as null
  always_comb begin
    if (unw_q) begin
      rd_link = seq_q;
    end else if (link_q >= mss_pkg::NULL_PTR) begin
      rd_link = mss_pkg::NULL_PTR;
    end else begin
      rd_link = link_q;
    end
  end

  assign rd_data = data_q;

endmodule

### hw/rtl/multi_stack_shared_store_core.sv
// ----------------------------------------------------------------------------
// multi_stack_shared_store_core
// Several LIFO stacks linked through one shared slot store with a free list.
// ----------------------------------------------------------------------------
// Each input transfer is a push or a pop on one stack and yields exactly one
// result transfer with a status and the popped value. An operation reads the
// addressed slot from the slot memories, whose read is registered, and then
// in the execute state updates the links, the stack tops and the free list
// head and loads the result register. A new operation is taken once the
// execute state is left, even while its result still waits, but the execute
// state stalls while an earlier result is not yet taken. No clearing pass
// follows reset: a fill count stands in for the link memory's reset image.
// ----------------------------------------------------------------------------
module multi_stack_shared_store_core (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // stack_sel[2:0], push_value[34:3], zero pad
  input  logic [0:0]  s_tuser,   // mode[0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // pop_value[31:0]
  output logic [1:0]  m_tuser    // status[1:0]
);

  mss_pkg::state_t  state;
  mss_pkg::state_t  state_next;

  // latched operation
  logic                          op_mode;
  logic                          op_sel_ok;
  logic [mss_pkg::STK_W-1:0]     op_idx;
  logic [mss_pkg::DATA_W-1:0]    op_value;
  mss_pkg::ptr_t                 op_slot;

  // list heads
  mss_pkg::ptr_t                 free_head;
  mss_pkg::ptr_t                 stack_top [mss_pkg::NUM_STACKS];

  // result register
  mss_pkg::status_t              out_status;
  logic [mss_pkg::DATA_W-1:0]    out_value;
  logic                          out_valid;

  // store interface
  mss_pkg::slot_rd_t             rd;
  mss_pkg::slot_wr_t             wr;
  mss_pkg::ptr_t                 rd_link;
  logic [mss_pkg::DATA_W-1:0]    rd_data;

  // decode of the incoming transfer
  logic                          in_accept;
  logic                          in_mode;
  logic [mss_pkg::SEL_W-1:0]     in_sel;
  logic [mss_pkg::SELX_W-1:0]    in_sel_x;
  logic [mss_pkg::STK_W-1:0]     in_idx;
  logic                          in_sel_ok;
  mss_pkg::ptr_t                 in_slot;

  // execute controls
  logic                          commit;
  logic                          slot_ok;
  logic                          push_ok;
  logic                          pop_ok;
  mss_pkg::status_t              exec_status;

  mss_slot_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd      (rd),
    .wr      (wr),
    .rd_link (rd_link),
    .rd_data (rd_data)
  );

  // input decode and slot select
  assign in_mode   = s_tuser[0];
  assign in_sel    = s_tdata[mss_pkg::SEL_W-1:0];
  assign in_sel_x  = mss_pkg::SELX_W'(in_sel);
  assign in_idx    = in_sel_x[mss_pkg::STK_W-1:0];
  assign in_sel_ok = (32'(in_sel) < mss_pkg::NUM_STACKS);
  assign in_slot   = (in_mode == mss_pkg::MODE_PUSH) ? free_head :
                     (in_sel_ok ? stack_top[in_idx] : mss_pkg::NULL_PTR);

  assign s_tready  = (state == mss_pkg::S_IDLE);
  assign in_accept = s_tvalid && s_tready;

  // next state, memory requests and result status
  always_comb begin
    state_next = state;
    commit     = (state == mss_pkg::S_EXEC) && (!out_valid || m_tready);
    slot_ok    = op_sel_ok && (op_slot < mss_pkg::NULL_PTR);
    push_ok    = slot_ok && (op_mode == mss_pkg::MODE_PUSH);
    pop_ok     = slot_ok && (op_mode == mss_pkg::MODE_POP);

    rd.en   = in_accept;
    rd.addr = in_slot[mss_pkg::ADDR_W-1:0];

    wr.link_en = commit && slot_ok;
    wr.data_en = commit && push_ok;
    wr.addr    = op_slot[mss_pkg::ADDR_W-1:0];
    wr.link    = push_ok ? stack_top[op_idx] : free_head;
    wr.data    = op_value;

    if (slot_ok) begin
      exec_status = mss_pkg::ST_OK;
    end else if (op_mode == mss_pkg::MODE_PUSH) begin
      exec_status = mss_pkg::ST_OVERFLOW;
    end else begin
      exec_status = mss_pkg::ST_UNDERFLOW;
    end

    case (state)
      mss_pkg::S_IDLE: begin
        if (in_accept) begin
          state_next = mss_pkg::S_EXEC;
        end
      end
      mss_pkg::S_EXEC: begin
        if (commit) begin
          state_next = mss_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mss_pkg::S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mss_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // operation latch
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_mode   <= in_mode;
      op_sel_ok <= in_sel_ok;
      op_idx    <= in_idx;
      op_value  <= s_tdata[mss_pkg::SEL_W +: mss_pkg::DATA_W];
      op_slot   <= in_slot;
    end
  end

  // free list head and stack tops
  always_ff @(posedge clk) begin
    if (rst) begin
      free_head <= '0;
      for (int i = 0; i < mss_pkg::NUM_STACKS; i++) begin
        stack_top[i] <= mss_pkg::NULL_PTR;
      end
    end else if (commit) begin
      if (push_ok) begin
        free_head         <= rd_link;
        stack_top[op_idx] <= op_slot;
      end else if (pop_ok) begin
        free_head         <= op_slot;
        stack_top[op_idx] <= rd_link;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_status <= exec_status;
      out_value  <= pop_ok ? rd_data : '0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_value;
  assign m_tuser  = out_status;

  // failed operations return zero (successful pushes also return zero, not checked here)
  a_fail_zero : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != mss_pkg::ST_OK) |-> (m_tdata == '0))
    else $error("nonzero value on a failed operation");

  // a result appears only out of the execute step
  a_result_src : assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == mss_pkg::S_EXEC))
    else $error("result without an execute step");

  // a successful push makes its slot the new top
  a_push_top : assert property (@(posedge clk) disable iff (rst)
    commit && push_ok |=> (stack_top[$past(op_idx)] == $past(op_slot)))
    else $error("push did not update stack top");

  // a successful pop returns its slot to the free list head
  a_pop_free : assert property (@(posedge clk) disable iff (rst)
    commit && pop_ok |=> (free_head == $past(op_slot)))
    else $error("pop did not free its slot");

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for multi_stack_shared_store_core.
// ----------------------------------------------------------------------------
// Drives push and pop transfers onto the input stream and keeps a shadow
// copy of the slot store, the free list and the stack tops to predict the
// status and popped value of every operation. Results are checked in order
// against the predicted queue. Directed corners come first, then a full
// fill to overflow and a drain, then random traffic with phases of push or
// pop bias. Both stream sides idle at random, with bursts of no idling.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 800;

  typedef struct packed {
    mss_pkg::status_t status;
    logic [31:0]      value;
  } stack_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // stack_sel[2:0], push_value[34:3], zero pad
  logic [0:0]  s_tuser;   // mode[0]
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // pop_value[31:0]
  logic [1:0]  m_tuser;   // status[1:0]

  // shadow copy of the store
  logic [31:0]   shadow_data [mss_pkg::DEPTH];
  mss_pkg::ptr_t shadow_link [mss_pkg::DEPTH];
  mss_pkg::ptr_t shadow_top  [mss_pkg::NUM_STACKS];
  mss_pkg::ptr_t shadow_free;
  int            stack_len   [mss_pkg::NUM_STACKS];
  int            used_slots;

  stack_result_t pending_results [$];
  int            mismatch_count = 0;
  int            cycle_count    = 0;
  bit            idle_on        = 1'b1;

  multi_stack_shared_store_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // clock, period 2
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic bit is_slot(mss_pkg::ptr_t p);
    return int'(p) < mss_pkg::DEPTH;
  endfunction

  // apply one operation to the shadow store and return its result
  function automatic stack_result_t apply_stack_op(logic op, logic [2:0] sel,
                                                   logic [31:0] val);
    stack_result_t res;
    mss_pkg::ptr_t slot;
    res.status = mss_pkg::ST_OK;
    res.value  = '0;
    if (op == mss_pkg::MODE_PUSH) begin
      slot = shadow_free;
      if (int'(sel) >= mss_pkg::NUM_STACKS || !is_slot(slot)) begin
        res.status = mss_pkg::ST_OVERFLOW;
      end else begin
        shadow_free       = is_slot(shadow_link[slot]) ? shadow_link[slot]
                                                       : mss_pkg::NULL_PTR;
        shadow_data[slot] = val;
        shadow_link[slot] = shadow_top[sel];
        shadow_top[sel]   = slot;
        stack_len[sel]++;
        used_slots++;
      end
    end else begin
      if (int'(sel) >= mss_pkg::NUM_STACKS || !is_slot(shadow_top[sel])) begin
        res.status = mss_pkg::ST_UNDERFLOW;
      end else begin
        slot              = shadow_top[sel];
        shadow_top[sel]   = is_slot(shadow_link[slot]) ? shadow_link[slot]
                                                       : mss_pkg::NULL_PTR;
        shadow_link[slot] = shadow_free;
        shadow_free       = slot;
        res.value         = shadow_data[slot];
        stack_len[sel]--;
        used_slots--;
      end
    end
    return res;
  endfunction

  // some stack that holds entries, or any stack when all are empty
  function automatic logic [2:0] pick_loaded_stack();
    int start;
    start = $urandom_range(0, mss_pkg::NUM_STACKS - 1);
    for (int i = 0; i < mss_pkg::NUM_STACKS; i++) begin
      if (stack_len[(start + i) % mss_pkg::NUM_STACKS] > 0)
        return 3'((start + i) % mss_pkg::NUM_STACKS);
    end
    return 3'(start);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // send one operation and queue its predicted result
  task automatic send_op(logic op, logic [2:0] sel, logic [31:0] val);
    int gap;
    gap = idle_on ? $urandom_range(0, 11) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, val, sel};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(apply_stack_op(op, sel, val));
  endtask

  // hold off the sender until every result is back
  task automatic wait_all_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result side: random stall before each transfer
  initial begin
    int stall;
    m_tready = 1'b0;
    forever begin
      stall = idle_on ? $urandom_range(0, 11) : 0;
      @(negedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && !rst));
    end
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    stack_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d pop_value %h", m_tuser, m_tdata);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tuser);
          mismatch_count++;
        end
        if (m_tdata !== want.value) begin
          $error("pop_value: expected %h, got %h", want.value, m_tdata);
          mismatch_count++;
        end
      end
    end
  end

  // corners: empty pops, extreme values on every stack, lifo order
  task automatic test_directed();
    logic [31:0] corner_vals [8] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
                                     32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa,
                                     32'h0000_0001, 32'hffff_fffe};
    idle_on = 1'b1;
    send_op(mss_pkg::MODE_POP, 3'd0, 32'hffff_ffff);
    send_op(mss_pkg::MODE_POP, 3'd7, 32'h0000_0000);
    for (int s = 0; s < mss_pkg::NUM_STACKS; s++)
      send_op(mss_pkg::MODE_PUSH, 3'(s), corner_vals[s]);
    send_op(mss_pkg::MODE_PUSH, 3'd2, 32'h1234_5678);
    for (int s = mss_pkg::NUM_STACKS - 1; s >= 0; s--)
      send_op(mss_pkg::MODE_POP, 3'(s), $urandom());
    send_op(mss_pkg::MODE_POP, 3'd2, $urandom());
    send_op(mss_pkg::MODE_POP, 3'd2, $urandom());
  endtask

  // fill every slot, push into the full store, then drain it all
  task automatic test_full_store();
    while (used_slots < mss_pkg::DEPTH) begin
      idle_on = ((used_slots / 64) % 2) != 0;
      send_op(mss_pkg::MODE_PUSH, 3'($urandom_range(0, mss_pkg::NUM_STACKS - 1)),
              pick_value());
    end
    idle_on = 1'b1;
    repeat (4)
      send_op(mss_pkg::MODE_PUSH, 3'($urandom_range(0, mss_pkg::NUM_STACKS - 1)),
              pick_value());
    wait_all_results();
    send_op(mss_pkg::MODE_POP, pick_loaded_stack(), $urandom());
    send_op(mss_pkg::MODE_PUSH, 3'($urandom_range(0, mss_pkg::NUM_STACKS - 1)),
            pick_value());
    send_op(mss_pkg::MODE_PUSH, 3'($urandom_range(0, mss_pkg::NUM_STACKS - 1)),
            pick_value());
    while (used_slots > 0) begin
      idle_on = ((used_slots / 40) % 2) != 0;
      send_op(mss_pkg::MODE_POP, pick_loaded_stack(), $urandom());
    end
    send_op(mss_pkg::MODE_POP, 3'($urandom_range(0, mss_pkg::NUM_STACKS - 1)),
            $urandom());
    wait_all_results();
  endtask

  // random traffic in phases of push or pop bias
  task automatic test_random();
    int          push_pct;
    int          focus;
    logic        op;
    logic [2:0]  sel;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 3))
          0:       push_pct = 15;
          1:       push_pct = 50;
          2:       push_pct = 85;
          default: push_pct = 97;
        endcase
        idle_on = $urandom_range(0, 3) != 0;
        focus   = $urandom_range(0, mss_pkg::NUM_STACKS - 1);
      end
      op = ($urandom_range(1, 100) <= push_pct) ? mss_pkg::MODE_PUSH : mss_pkg::MODE_POP;
      if (op == mss_pkg::MODE_POP && $urandom_range(0, 4) != 0) begin
        sel = pick_loaded_stack();
      end else if ($urandom_range(0, 1) != 0) begin
        sel = 3'(focus);
      end else begin
        sel = 3'($urandom_range(0, mss_pkg::NUM_STACKS - 1));
      end
      send_op(op, sel, pick_value());
      if (n == RANDOM_ITEMS / 2) wait_all_results();
    end
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    // shadow reset image
    for (int i = 0; i < mss_pkg::DEPTH; i++) begin
      shadow_data[i] = '0;
      shadow_link[i] = (i + 1 < mss_pkg::DEPTH) ? mss_pkg::ptr_t'(i + 1)
                                                : mss_pkg::NULL_PTR;
    end
    for (int s = 0; s < mss_pkg::NUM_STACKS; s++) begin
      shadow_top[s] = mss_pkg::NULL_PTR;
      stack_len[s]  = 0;
    end
    shadow_free = '0;
    used_slots  = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_full_store();
    test_random();

    wait_all_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
